FILE: sv/rsh_pkg.sv
// Package for running_stats_histogram: constants and channel payload types.
`default_nettype none
package rsh_pkg;
    localparam int MAX_BOUNDARIES = 7;
    localparam int FRACTION_BITS  = 16;
    localparam int NUM_BND        = 7;
    localparam int IDX_W          = $clog2(MAX_BOUNDARIES + 1);
    localparam int REG_IDX_W      = 3;
    localparam int PADDR_W        = REG_IDX_W + 2;
    localparam int X_W            = 32 + FRACTION_BITS;
    localparam int DELTA_W        = X_W + 1;
    localparam int LO_W           = (DELTA_W + 1) / 2;
    localparam int HI_W           = DELTA_W - LO_W;
    localparam int PP_W           = 2 * LO_W;
    localparam int PROD_W         = 2 * DELTA_W;
    localparam int STEP_W         = $clog2(DELTA_W + 1);

    localparam logic [REG_IDX_W-1:0] REG_BIU = '0;
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;
    localparam logic KIND_STATS  = 1'b0;
    localparam logic KIND_BUCKET = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [31:0]        total_count;
        logic signed [47:0] mean_value;
        logic [63:0]        squared_deviation;
        logic signed [31:0] smallest_seen;
        logic signed [31:0] largest_seen;
        logic               count_overflow;
        logic [2:0]         bucket_index;
        logic [31:0]        bucket_total;
        logic               last_of_run;
    } out_item_t;
endpackage
`default_nettype wire

FILE: sv/running_stats_histogram.sv
// Streaming count, mean, squared deviation, min/max and histogram over signed samples.
//
//  channel | ports                                   | moves
//  s_      | s_valid s_ready s_data                  | add or read request
//  m_      | m_valid m_ready m_data                  | statistics or bucket result
//  apb     | psel penable pwrite paddr pwdata prdata | boundary registers
//
// An add holds the sequencer from acceptance to the next s_ready: it loads the sample, runs
// the bit-serial divide of the mean update by the count, applies the mean, forms the four
// partial products (up to 25x25) of the squared deviation, accumulates and loads the result.
// A dropped add goes straight to loading the result; a read loads one result per bucket.
// Reset clears all statistics and bucket counts at once. A stalled m_ready holds the
// output register and, in its result states, the sequencer; s_ready is high only when idle.
`default_nettype none
module running_stats_histogram (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rsh_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire rsh_pkg::in_item_t            s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output rsh_pkg::out_item_t                m_data
);
    import rsh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MEAN, ST_MUL, ST_ACC, ST_STATS, ST_RUN
    } state_t;

    state_t                   state_reg;
    logic [2:0]               biu_reg;
    logic [31:0]              bnd_reg [NUM_BND];
    logic [31:0]              cnt_reg;
    logic signed [X_W-1:0]    mean_reg;
    logic [63:0]              sqd_reg;
    logic signed [31:0]       min_reg;
    logic signed [31:0]       max_reg;
    logic [31:0]              bucket_reg [MAX_BOUNDARIES+1];
    logic [X_W-1:0]           x_reg;
    logic                     neg_reg;
    logic [DELTA_W-1:0]       quo_reg;
    logic [31:0]              rem_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [DELTA_W-1:0]       mag_a_reg;
    logic [DELTA_W-1:0]       mag_b_reg;
    logic [PP_W-1:0]          pp_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [1:0]               sh_sel_reg;
    logic                     ovf_reg;
    logic [IDX_W-1:0]         run_reg;
    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     cfg_wr;
    logic [IDX_W-1:0]         n_act;
    logic [IDX_W-1:0]         bidx;
    logic [X_W-1:0]           x_in;
    logic [DELTA_W-1:0]       delta_in;
    logic [DELTA_W-1:0]       mag_in;
    logic [32:0]              rem_sh;
    logic                     div_ge;
    logic [DELTA_W:0]         q_signed;
    logic [X_W-1:0]           mean_new;
    logic [DELTA_W-1:0]       delta2;
    logic [DELTA_W-1:0]       mag2;
    logic [LO_W-1:0]          a_part;
    logic [LO_W-1:0]          b_part;
    logic [PROD_W-1:0]        pp_shifted;
    logic [63:0]              add_val;
    logic [64:0]              sum65;
    logic                     out_free;
    logic                     out_load;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[PADDR_W-1:2];
    assign cfg_wr   = psel && penable && pwrite;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && (state_reg == ST_STATS || state_reg == ST_RUN);

    always_comb begin
        if (reg_idx == REG_BIU) begin
            prdata = {29'd0, biu_reg};
        end else begin
            prdata = bnd_reg[reg_idx - 3'd1];
        end
    end

    assign n_act = (biu_reg > 3'(MAX_BOUNDARIES)) ? IDX_W'(MAX_BOUNDARIES)
                                                  : IDX_W'(biu_reg);

    // count boundaries in use that are not above the sample
    always_comb begin
        bidx = '0;
        for (int i = 0; i < MAX_BOUNDARIES; i++) begin
            if (i < int'(n_act) && $signed(bnd_reg[i]) <= s_data.sample) begin
                bidx = bidx + 1'b1;
            end
        end
    end

    assign x_in     = {s_data.sample, {FRACTION_BITS{1'b0}}};
    assign delta_in = {x_in[X_W-1], x_in} - {mean_reg[X_W-1], mean_reg};
    assign mag_in   = delta_in[DELTA_W-1] ? (~delta_in + 1'b1) : delta_in;

    assign rem_sh   = {rem_reg, quo_reg[DELTA_W-1]};
    assign div_ge   = rem_sh >= {1'b0, cnt_reg};

    assign q_signed = neg_reg ? (~{1'b0, quo_reg} + 1'b1) : {1'b0, quo_reg};
    assign mean_new = mean_reg + q_signed[X_W-1:0];
    assign delta2   = {x_reg[X_W-1], x_reg} - {mean_new[X_W-1], mean_new};
    assign mag2     = delta2[DELTA_W-1] ? (~delta2 + 1'b1) : delta2;

    assign a_part = step_reg[1] ? LO_W'(mag_a_reg[DELTA_W-1:LO_W]) : mag_a_reg[LO_W-1:0];
    assign b_part = step_reg[0] ? LO_W'(mag_b_reg[DELTA_W-1:LO_W]) : mag_b_reg[LO_W-1:0];
    assign pp_shifted = PROD_W'(pp_reg) << ((sh_sel_reg[1] ? LO_W : 0)
                                          + (sh_sel_reg[0] ? LO_W : 0));

    assign add_val = (acc_reg[PROD_W-1:64+FRACTION_BITS] != '0) ? '1
                   : acc_reg[64+FRACTION_BITS-1:FRACTION_BITS];
    assign sum65   = {1'b0, sqd_reg} + {1'b0, add_val};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            biu_reg     <= '0;
            for (int i = 0; i < NUM_BND; i++) bnd_reg[i] <= '0;
            cnt_reg     <= '0;
            mean_reg    <= '0;
            sqd_reg     <= '0;
            min_reg     <= 32'sh7FFFFFFF;
            max_reg     <= 32'sh80000000;
            for (int i = 0; i <= MAX_BOUNDARIES; i++) bucket_reg[i] <= '0;
            m_valid_reg <= 1'b0;
            run_reg     <= '0;
            step_reg    <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (reg_idx == REG_BIU) begin
                    biu_reg <= pwdata[2:0];
                end else begin
                    bnd_reg[reg_idx - 3'd1] <= pwdata;
                end
            end

            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.cmd == CMD_READ) begin
                            run_reg   <= '0;
                            state_reg <= ST_RUN;
                        end else if (cnt_reg == '1) begin
                            ovf_reg   <= 1'b1;
                            state_reg <= ST_STATS;
                        end else begin
                            ovf_reg   <= 1'b0;
                            cnt_reg   <= cnt_reg + 32'd1;
                            x_reg     <= x_in;
                            neg_reg   <= delta_in[DELTA_W-1];
                            quo_reg   <= mag_in;
                            mag_a_reg <= mag_in;
                            rem_reg   <= '0;
                            step_reg  <= '0;
                            if (s_data.sample < min_reg) min_reg <= s_data.sample;
                            if (s_data.sample > max_reg) max_reg <= s_data.sample;
                            if (bucket_reg[bidx] != '1) begin
                                bucket_reg[bidx] <= bucket_reg[bidx] + 32'd1;
                            end
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg  <= div_ge ? 32'(rem_sh - {1'b0, cnt_reg}) : rem_sh[31:0];
                    quo_reg  <= {quo_reg[DELTA_W-2:0], div_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DELTA_W - 1)) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    mean_reg  <= mean_new;
                    mag_b_reg <= mag2;
                    acc_reg   <= '0;
                    pp_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // multiply one quarter, add the previous one
                    pp_reg     <= PP_W'(a_part) * PP_W'(b_part);
                    sh_sel_reg <= step_reg[1:0];
                    if (step_reg != '0) begin
                        acc_reg <= acc_reg + pp_shifted;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(4)) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    sqd_reg   <= sum65[64] ? '1 : sum65[63:0];
                    state_reg <= ST_STATS;
                end
                ST_STATS: begin
                    if (out_free) begin
                        m_valid_reg                  <= 1'b1;
                        m_data_reg.result_kind       <= KIND_STATS;
                        m_data_reg.total_count       <= cnt_reg;
                        m_data_reg.mean_value        <= mean_reg;
                        m_data_reg.squared_deviation <= sqd_reg;
                        m_data_reg.smallest_seen     <= min_reg;
                        m_data_reg.largest_seen      <= max_reg;
                        m_data_reg.count_overflow    <= ovf_reg;
                        m_data_reg.bucket_index      <= '0;
                        m_data_reg.bucket_total      <= '0;
                        m_data_reg.last_of_run       <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end
                ST_RUN: begin
                    if (out_free) begin
                        m_valid_reg                  <= 1'b1;
                        m_data_reg.result_kind       <= KIND_BUCKET;
                        m_data_reg.total_count       <= '0;
                        m_data_reg.mean_value        <= '0;
                        m_data_reg.squared_deviation <= '0;
                        m_data_reg.smallest_seen     <= '0;
                        m_data_reg.largest_seen      <= '0;
                        m_data_reg.count_overflow    <= 1'b0;
                        m_data_reg.bucket_index      <= 3'(run_reg);
                        m_data_reg.bucket_total      <= bucket_reg[run_reg];
                        m_data_reg.last_of_run       <= (run_reg == n_act);
                        run_reg                      <= run_reg + 1'b1;
                        if (run_reg == n_act) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
